[hdl/ptcc_pkg.sv]
// shared types, constants and codes for the pixel tanh charge calibration block
package ptcc_pkg;

  localparam int NUM_CHIPS   = 8;
  localparam int NUM_COLUMNS = 64;
  localparam int NUM_ROWS    = 128;
  localparam int DEPTH       = NUM_CHIPS * NUM_COLUMNS * NUM_ROWS;

  localparam int CHIP_W = 3;
  localparam int COL_W  = 6;
  localparam int ROW_W  = 7;
  localparam int ADDR_W = CHIP_W + COL_W + ROW_W;

  localparam int GAIN_W = 32;
  localparam int OFF_W  = 24;
  localparam int AMP_W  = 20;
  localparam int VOFF_W = 20;
  localparam int SIG_W  = 12;
  localparam int WORD_W = GAIN_W + OFF_W + AMP_W + VOFF_W;

  // log2 unit
  localparam int X_W       = 20;
  localparam int E_W       = 5;
  localparam int LOG_FRAC  = 24;
  localparam int MANT_FRAC = 30;
  localparam int MANT_W    = MANT_FRAC + 1;
  localparam int LOG_W     = E_W + LOG_FRAC;
  localparam int LOG_LAT   = LOG_FRAC + 1;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam int CAL_W = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_HIT  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_GAIN  = 2'd2;

  typedef struct packed {
    logic [CHIP_W-1:0] chip;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic              bad_range;
    logic              zero_gain;
  } ctl_t;

  typedef struct packed {
    ctl_t                     ctl;
    logic                     neg;
    logic signed [OFF_W-1:0]  off;
    logic signed [GAIN_W-1:0] gain;
  } log_carry_t;

endpackage

[hdl/ptcc_log2.sv]
// pipelined log2 in q.24: normalize, then one squaring per fraction bit
module ptcc_log2 (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ptcc_pkg::X_W-1:0]    x,
  output logic [ptcc_pkg::LOG_W-1:0]  res
);

  logic [ptcc_pkg::E_W-1:0]    e;
  logic [ptcc_pkg::MANT_W-1:0] y0;
  logic [ptcc_pkg::MANT_W-1:0] y_r   [0:ptcc_pkg::LOG_FRAC];
  logic [ptcc_pkg::LOG_W-1:0]  res_r [0:ptcc_pkg::LOG_FRAC];

  // leading one position
  always_comb begin
    e = '0;
    for (int i = 0; i < ptcc_pkg::X_W; i++) begin
      if (x[i]) e = ptcc_pkg::E_W'(i);
    end
    y0 = ptcc_pkg::MANT_W'(x) << (ptcc_pkg::E_W'(ptcc_pkg::MANT_FRAC) - e);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r[0]   <= y0;
      res_r[0] <= {e, {ptcc_pkg::LOG_FRAC{1'b0}}};
    end
  end

  for (genvar k = 1; k <= ptcc_pkg::LOG_FRAC; k++) begin : g_sq
    logic [2*ptcc_pkg::MANT_W-1:0] sq;
    logic [ptcc_pkg::MANT_W:0]     t;
    assign sq = y_r[k-1] * y_r[k-1];
    assign t  = sq[2*ptcc_pkg::MANT_W-1:ptcc_pkg::MANT_FRAC];
    always_ff @(posedge clk) begin
      if (en) begin
        if (t[ptcc_pkg::MANT_W]) begin
          y_r[k]   <= t[ptcc_pkg::MANT_W:1];
          res_r[k] <= res_r[k-1] | (ptcc_pkg::LOG_W'(1) << (ptcc_pkg::LOG_FRAC - k));
        end else begin
          y_r[k]   <= t[ptcc_pkg::MANT_W-1:0];
          res_r[k] <= res_r[k-1];
        end
      end
    end
  end

  assign res = res_r[ptcc_pkg::LOG_FRAC];

endmodule

[hdl/pixel_tanh_charge_calibration.sv]
// top level: per-pixel parameter memory and the calibration pipeline
//
// input channel (in_valid/in_ready) carries load and hit transactions.
// a load writes the gain, offset, amplitude and voff of one pixel into
// the parameter memory and gives no result. a hit reads its pixel's
// parameters and gives exactly one result transaction on the out_ channel
// with the echoed coordinates, the calibrated charge and a status code.
// one transaction is accepted per cycle while in_ready is high, loads
// and hits mixed freely. a hit's result passes, once its acceptance edge
// has registered the memory read, through the two log2 units (range
// check folded into their first stage, one squaring per fraction bit),
// the ln2 scaling, atanh and numerator work, the saturation check, the
// restoring divider (one quotient bit per stage) and the output register.
// a load is written at its acceptance edge, so a hit right behind it
// already sees the new parameters.
// when the receiver stalls with a result waiting, the whole pipeline
// holds and in_ready drops; nothing is lost or repeated.
// reset clears the stage valid bits only and holds in_ready low; the
// memory content is undefined until each pixel has been loaded.
module pixel_tanh_charge_calibration (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic [ptcc_pkg::CHIP_W-1:0]        in_chip,
  input  logic [ptcc_pkg::COL_W-1:0]         in_column,
  input  logic [ptcc_pkg::ROW_W-1:0]         in_row,
  input  logic signed [ptcc_pkg::SIG_W-1:0]  in_signal,
  input  logic signed [ptcc_pkg::GAIN_W-1:0] in_gain_in,
  input  logic signed [ptcc_pkg::OFF_W-1:0]  in_offset_in,
  input  logic signed [ptcc_pkg::AMP_W-1:0]  in_amplitude_in,
  input  logic signed [ptcc_pkg::VOFF_W-1:0] in_voff_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ptcc_pkg::CHIP_W-1:0]        out_chip,
  output logic [ptcc_pkg::COL_W-1:0]         out_column,
  output logic [ptcc_pkg::ROW_W-1:0]         out_row,
  output logic signed [ptcc_pkg::CAL_W-1:0]  out_calibrated,
  output logic [1:0]                         out_status
);

  // stage numbering: 0 memory read, 1..25 log2, 26 products, 27 atanh,
  // 28 numerator, 29 saturation, 30..45 divider, 46 output
  localparam int DIV_N  = ptcc_pkg::CAL_W;
  localparam int ST_LOG = 1;
  localparam int ST_P   = ST_LOG + ptcc_pkg::LOG_LAT;
  localparam int ST_T   = ST_P + 1;
  localparam int ST_U   = ST_T + 1;
  localparam int ST_V   = ST_U + 1;
  localparam int ST_OUT = ST_V + DIV_N + 1;
  localparam int NSTG   = ST_OUT + 1;
  localparam int REM_W  = ptcc_pkg::GAIN_W + DIV_N;
  localparam int AT_W   = 21;
  localparam int NUM_W  = 34;

  typedef struct packed {
    ptcc_pkg::ctl_t   ctl;
    logic             qneg;
    logic             sat;
  } div_carry_t;

  logic en, accept;
  logic [NSTG-1:0] vld_r;
  logic [ptcc_pkg::ADDR_W-1:0] addr;

  // parameter memory, one word per pixel: gain, offset, amplitude, voff
  logic [ptcc_pkg::WORD_W-1:0] mem [0:ptcc_pkg::DEPTH-1];
  logic [ptcc_pkg::WORD_W-1:0] rd_r;
  ptcc_pkg::ctl_t              f1_r;
  logic signed [ptcc_pkg::SIG_W-1:0] sig1_r;

  assign en       = !(vld_r[ST_OUT] && !out_ready);
  assign in_ready = rst_n && en;
  assign accept   = in_valid && in_ready;
  assign addr     = {in_chip, in_column, in_row};

  always_ff @(posedge clk) begin
    if (accept && in_opcode == ptcc_pkg::OP_LOAD) begin
      mem[addr] <= {in_gain_in, in_offset_in, in_amplitude_in, in_voff_in};
    end
    if (en) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r.chip      <= in_chip;
      f1_r.column    <= in_column;
      f1_r.row       <= in_row;
      f1_r.bad_range <= 1'b0;
      f1_r.zero_gain <= 1'b0;
      sig1_r         <= in_signal;
    end
  end

  // valid bits, one per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], accept && in_opcode == ptcc_pkg::OP_HIT};
    end
  end

  // range check: n = signal*256 - voff, both signs folded onto amplitude
  logic signed [ptcc_pkg::GAIN_W-1:0] g1;
  logic signed [ptcc_pkg::OFF_W-1:0]  off1;
  logic signed [ptcc_pkg::AMP_W:0]    a_s;
  logic signed [21:0]                 n_s, n_adj;
  logic [ptcc_pkg::AMP_W:0]           a_abs, m;
  logic [ptcc_pkg::X_W-1:0]           x_hi, x_lo;
  ptcc_pkg::log_carry_t               c1;

  always_comb begin
    g1    = rd_r[ptcc_pkg::WORD_W-1 -: ptcc_pkg::GAIN_W];
    off1  = rd_r[ptcc_pkg::AMP_W+ptcc_pkg::VOFF_W +: ptcc_pkg::OFF_W];
    a_s   = 21'(signed'(rd_r[ptcc_pkg::VOFF_W +: ptcc_pkg::AMP_W]));
    n_s   = 22'(signed'({sig1_r, 8'b0})) - 22'(signed'(rd_r[ptcc_pkg::VOFF_W-1:0]));
    if (a_s < 0) begin
      a_abs = 21'(-a_s);
      n_adj = -n_s;
    end else begin
      a_abs = 21'(a_s);
      n_adj = n_s;
    end
    m     = n_adj[21] ? 21'(-n_adj) : 21'(n_adj);
    x_hi  = ptcc_pkg::X_W'(a_abs + m);
    x_lo  = ptcc_pkg::X_W'(a_abs - m);
    c1.ctl           = f1_r;
    c1.ctl.bad_range = (a_abs == '0) || (m >= a_abs);
    c1.ctl.zero_gain = (g1 == '0);
    c1.neg           = n_adj[21];
    c1.off           = off1;
    c1.gain          = g1;
  end

  logic [ptcc_pkg::LOG_W-1:0] l_hi, l_lo;

  ptcc_log2 u_log_hi (.clk(clk), .en(en), .x(x_hi), .res(l_hi));
  ptcc_log2 u_log_lo (.clk(clk), .en(en), .x(x_lo), .res(l_lo));

  // side data follows the log2 units
  ptcc_pkg::log_carry_t lc_r [0:ptcc_pkg::LOG_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      lc_r[0] <= c1;
      for (int i = 1; i < ptcc_pkg::LOG_LAT; i++) lc_r[i] <= lc_r[i-1];
    end
  end

  // atanh = (d * ln2 + 2^40) >> 41, product split into two halves
  logic [ptcc_pkg::LOG_W-1:0] d;
  logic [47:0] p_lo_r;
  logic [44:0] p_hi_r;
  ptcc_pkg::log_carry_t pc_r, tc_r;
  logic [61:0] psum;
  logic [AT_W-1:0] at_r;

  assign d    = l_hi - l_lo;
  assign psum = 62'(p_lo_r) + {1'b0, p_hi_r, 16'b0} + (62'(1) << 40);

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo_r <= d[15:0] * ptcc_pkg::LN2_Q32;
      p_hi_r <= d[ptcc_pkg::LOG_W-1:16] * ptcc_pkg::LN2_Q32;
      pc_r   <= lc_r[ptcc_pkg::LOG_LAT-1];
      at_r   <= psum[61:41];
      tc_r   <= pc_r;
    end
  end

  // numerator magnitude and quotient sign
  logic signed [25:0]    s_val;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]      un_r;
  logic [ptcc_pkg::GAIN_W-1:0] ug_r;
  div_carry_t            uc_r;

  always_comb begin
    s_val = (tc_r.neg ? -26'(at_r) : 26'(at_r)) + 26'(tc_r.off);
    num   = {s_val, 8'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      un_r     <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      ug_r     <= tc_r.gain[ptcc_pkg::GAIN_W-1] ? ptcc_pkg::GAIN_W'(-tc_r.gain)
                                                  : ptcc_pkg::GAIN_W'(tc_r.gain);
      uc_r.ctl  <= tc_r.ctl;
      uc_r.qneg <= num[NUM_W-1] != tc_r.gain[ptcc_pkg::GAIN_W-1];
      uc_r.sat  <= 1'b0;
    end
  end

  // quotient of 2^16 or more saturates either way
  logic [REM_W-1:0]            rem_r [0:DIV_N];
  logic [DIV_N-1:0]            q_r   [0:DIV_N];
  logic [ptcc_pkg::GAIN_W-1:0] dv_r  [0:DIV_N];
  div_carry_t                  dc_r  [0:DIV_N];
  div_carry_t                  dc0;

  always_comb begin
    dc0     = uc_r;
    dc0.sat = REM_W'(un_r) >= {ug_r, {DIV_N{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]     <= REM_W'(un_r);
      q_r[0]       <= '0;
      dv_r[0]      <= ug_r;
      dc_r[0]      <= dc0;
    end
  end

  for (genvar k = 1; k <= DIV_N; k++) begin : g_div
    logic [REM_W-1:0] trial;
    assign trial = REM_W'(dv_r[k-1]) << (DIV_N - k);
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k] <= dv_r[k-1];
        dc_r[k] <= dc_r[k-1];
        if (rem_r[k-1] >= trial) begin
          rem_r[k] <= rem_r[k-1] - trial;
          q_r[k]   <= q_r[k-1] | (DIV_N'(1) << (DIV_N - k));
        end else begin
          rem_r[k] <= rem_r[k-1];
          q_r[k]   <= q_r[k-1];
        end
      end
    end
  end

  // final selection into the output register
  div_carry_t       fc;
  logic [DIV_N-1:0] q;
  logic signed [ptcc_pkg::CAL_W-1:0] cal_nxt;
  logic [1:0]       st_nxt;
  logic [ptcc_pkg::CHIP_W-1:0] chip_r;
  logic [ptcc_pkg::COL_W-1:0]  column_r;
  logic [ptcc_pkg::ROW_W-1:0]  row_r;
  logic signed [ptcc_pkg::CAL_W-1:0] cal_r;
  logic [1:0]       st_r;

  always_comb begin
    fc = dc_r[DIV_N];
    q  = q_r[DIV_N];
    cal_nxt = '0;
    st_nxt  = ptcc_pkg::ST_OK;
    if (fc.ctl.bad_range) begin
      st_nxt = ptcc_pkg::ST_RANGE;
    end else if (fc.ctl.zero_gain) begin
      st_nxt = ptcc_pkg::ST_GAIN;
    end else if (!fc.qneg && (fc.sat || q > 16'd32767)) begin
      cal_nxt = 16'sh7fff;
      st_nxt  = ptcc_pkg::ST_GAIN;
    end else if (fc.qneg && (fc.sat || q > 16'd32768)) begin
      cal_nxt = -16'sh8000;
      st_nxt  = ptcc_pkg::ST_GAIN;
    end else begin
      cal_nxt = fc.qneg ? -signed'(q) : signed'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chip_r   <= fc.ctl.chip;
      column_r <= fc.ctl.column;
      row_r    <= fc.ctl.row;
      cal_r    <= cal_nxt;
      st_r     <= st_nxt;
    end
  end

  assign out_valid      = vld_r[ST_OUT];
  assign out_chip       = chip_r;
  assign out_column     = column_r;
  assign out_row        = row_r;
  assign out_calibrated = cal_r;
  assign out_status     = st_r;

endmodule
